// ----- sv/laplacian_zero_crossing_edge_macros.svh -----
// ---------------------------------------------------------------------------
// Laplacian zero-crossing edge detector: assertion macros
// Concurrent assertion helpers shared by the RTL modules.
// ---------------------------------------------------------------------------
`ifndef LAPLACIAN_ZERO_CROSSING_EDGE_MACROS_SVH
`define LAPLACIAN_ZERO_CROSSING_EDGE_MACROS_SVH

// same-cycle implication, disabled during reset
`define LZCE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LZCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lzce_pkg.sv -----
// ---------------------------------------------------------------------------
// lzce_pkg
// Types, constants and crossing arithmetic for the zero-crossing detector.
// ---------------------------------------------------------------------------
package lzce_pkg;

    localparam int MaxWidth    = 4096;
    localparam int SampleBits  = 16;
    localparam int CoordBits   = $clog2(MaxWidth);
    localparam int DimBits     = 13;
    localparam int ThrBits     = 18;
    localparam int StrBits     = 18;
    localparam int MagBits     = SampleBits + 1;
    localparam int CfgAddrBits = 2;
    localparam int OutDataBits = 48;

    typedef logic signed [SampleBits-1:0] t_sample;
    typedef logic [CoordBits-1:0]         t_coord;
    typedef logic [DimBits-1:0]           t_dim;
    typedef logic [ThrBits-1:0]           t_thresh;
    typedef logic [StrBits-1:0]           t_strength;
    typedef logic [MagBits-1:0]           t_mag;

    localparam t_dim DimMin        = 13'd3;
    localparam t_dim WidthMax      = 13'd4096;
    localparam t_dim HeightMax     = 13'd4096;
    localparam t_dim WidthReset    = 13'd640;
    localparam t_dim HeightReset   = 13'd480;
    localparam t_thresh ThrReset   = 18'd10;

    typedef enum logic [CfgAddrBits-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } t_cfg_index;

    // position of one accepted sample and what it reports
    typedef struct packed {
        t_coord col;
        t_coord row;
        logic   emit;
        logic   done;
    } t_pos;

    // delayed write into the second line store
    typedef struct packed {
        logic    en;
        t_coord  col;
        t_sample data;
    } t_wb;

    function automatic t_dim clamp_dim(t_dim v, t_dim hi);
        t_dim r;
        if (v < DimMin) begin
            r = DimMin;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic t_mag abs_mag(t_sample v);
        t_mag ext;
        ext = {v[SampleBits-1], v};
        return v[SampleBits-1] ? (t_mag'(0) - ext) : ext;
    endfunction

    // |a|+|b| when a (or its stand-in) and b are nonzero with opposite signs
    function automatic t_mag part_mag(t_sample a, t_sample b, t_sample stand_in);
        t_sample a_eff;
        logic    opp;
        a_eff = (a == '0) ? stand_in : a;
        opp   = (a_eff != '0) && (b != '0) && (a_eff[SampleBits-1] != b[SampleBits-1]);
        return opp ? (abs_mag(a_eff) + abs_mag(b)) : '0;
    endfunction

endpackage

// ----- sv/lzce_position.sv -----
// ---------------------------------------------------------------------------
// lzce_position
// Configuration registers and raster counters; flags interior pixels.
// ---------------------------------------------------------------------------
module lzce_position (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lzce_pkg::CfgAddrBits-1:0]    i_cfg_addr,
    input  logic [lzce_pkg::ThrBits-1:0]        i_cfg_wdata,
    input  logic                                i_accept,
    input  logic                                i_frame_start,
    output lzce_pkg::t_pos                      o_pos,
    output lzce_pkg::t_thresh                   o_threshold
);
    import lzce_pkg::*;

    `include "laplacian_zero_crossing_edge_macros.svh"

    t_dim    r_width;
    t_dim    r_height;
    t_thresh r_threshold;
    t_coord  r_col;
    t_coord  r_row;
    t_coord  n_col;
    t_coord  n_row;

    t_dim    w;
    t_dim    h;
    t_coord  col0;
    t_coord  row0;
    t_dim    col_ext;
    t_dim    row_ext;

    always_comb begin
        w       = clamp_dim(r_width, WidthMax);
        h       = clamp_dim(r_height, HeightMax);
        col0    = i_frame_start ? '0 : r_col;
        row0    = i_frame_start ? '0 : r_row;
        col_ext = {1'b0, col0};
        row_ext = {1'b0, row0};

        o_pos.col  = col0;
        o_pos.row  = row0;
        o_pos.emit = (row0 >= t_coord'(2)) && (row_ext < h)
                  && (col0 >= t_coord'(2)) && (col_ext < w);
        o_pos.done = (row_ext == h - t_dim'(1)) && (col_ext == w - t_dim'(1));

        if (col_ext + t_dim'(1) >= w) begin
            n_col = '0;
            n_row = (row_ext + t_dim'(1) >= h) ? '0 : row0 + t_coord'(1);
        end else begin
            n_col = col0 + t_coord'(1);
            n_row = row0;
        end
    end

    assign o_threshold = r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WidthReset;
            r_height    <= HeightReset;
            r_threshold <= ThrReset;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_addr))
                    CFG_FRAME_WIDTH:    r_width     <= i_cfg_wdata[DimBits-1:0];
                    CFG_FRAME_HEIGHT:   r_height    <= i_cfg_wdata[DimBits-1:0];
                    CFG_EDGE_THRESHOLD: r_threshold <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    `LZCE_ASSERT_NEXT(a_frame_start_restart, i_clk, i_rst_n, i_accept && i_frame_start,
        r_col == t_coord'(1) && r_row == '0, "frame start did not restart the raster")
    `LZCE_ASSERT_SAME(a_done_is_interior, i_clk, i_rst_n, o_pos.done,
        o_pos.emit, "last pixel flagged outside the interior")

endmodule

// ----- sv/lzce_line_store.sv -----
// ---------------------------------------------------------------------------
// lzce_line_store
// Two row memories with registered reads, a fill count standing in for
// their zero reset, and a bypass for the delayed second-store write.
// ---------------------------------------------------------------------------
module lzce_line_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  lzce_pkg::t_coord    i_rd_col,
    input  lzce_pkg::t_sample   i_sample,
    input  lzce_pkg::t_wb       i_wb,
    output lzce_pkg::t_sample   o_above,
    output lzce_pkg::t_sample   o_two_above
);
    import lzce_pkg::*;

    `include "laplacian_zero_crossing_edge_macros.svh"

    t_sample mem_above [MaxWidth];
    t_sample mem_two   [MaxWidth];

    t_sample r_rd_above;
    t_sample r_rd_two;
    t_sample r_bypass_data;
    logic    r_use_bypass;
    logic    r_va;
    logic    r_vb;
    t_dim    r_fill;
    t_dim    n_fill;
    logic    hit;
    logic    in_fill;

    always_comb begin
        in_fill = {1'b0, i_rd_col} < r_fill;
        hit     = i_wb.en && (i_wb.col == i_rd_col);
        n_fill  = ({1'b0, i_rd_col} + t_dim'(1) > r_fill)
                ? {1'b0, i_rd_col} + t_dim'(1) : r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_above         <= mem_above[i_rd_col];
            mem_above[i_rd_col] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_two <= mem_two[i_rd_col];
        end
        if (i_wb.en) begin
            mem_two[i_wb.col] <= i_wb.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_bypass_data <= i_wb.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_va         <= 1'b0;
            r_vb         <= 1'b0;
            r_use_bypass <= 1'b0;
        end else if (i_rd_en) begin
            r_fill       <= n_fill;
            r_va         <= in_fill;
            r_vb         <= in_fill || hit;
            r_use_bypass <= hit;
        end
    end

    assign o_above     = r_va ? r_rd_above : '0;
    assign o_two_above = !r_vb ? '0 : (r_use_bypass ? r_bypass_data : r_rd_two);

    `LZCE_ASSERT_NEXT(a_fill_monotonic, i_clk, i_rst_n, 1'b1,
        r_fill >= $past(r_fill), "line store fill count went backwards")

endmodule

// ----- sv/lzce_crossing.sv -----
// ---------------------------------------------------------------------------
// lzce_crossing
// Window registers, crossing strength and threshold, and the result register.
// ---------------------------------------------------------------------------
module lzce_crossing (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  lzce_pkg::t_sample                   i_sample,
    input  lzce_pkg::t_pos                      i_pos,
    input  lzce_pkg::t_sample                   i_above,
    input  lzce_pkg::t_sample                   i_two_above,
    input  lzce_pkg::t_thresh                   i_threshold,
    input  logic                                i_m_tready,
    output logic                                o_s_ready,
    output lzce_pkg::t_wb                       o_wb,
    output logic                                o_m_valid,
    output logic [lzce_pkg::OutDataBits-1:0]    o_m_data,
    output logic                                o_m_last
);
    import lzce_pkg::*;

    `include "laplacian_zero_crossing_edge_macros.svh"

    logic      r1_valid;
    t_pos      r1_pos;
    t_sample   r1_sample;
    t_sample   r_centre;
    t_sample   r_left;
    t_sample   r_up;
    t_sample   r_below;
    logic      r_out_valid;
    logic      r_out_edge;
    t_strength r_out_str;
    t_coord    r_out_col;
    t_coord    r_out_row;
    logic      r_out_last;

    logic      advance;
    t_mag      h_mag;
    t_mag      v_mag;
    t_strength strength;

    always_comb begin
        advance   = r1_valid && (!r_out_valid || i_m_tready);
        o_s_ready = !r1_valid || advance;
        h_mag     = part_mag(r_centre, i_above, r_left);
        v_mag     = part_mag(r_centre, r_below, r_up);
        strength  = t_strength'(h_mag) + t_strength'(v_mag);
        o_wb.en   = advance;
        o_wb.col  = r1_pos.col;
        o_wb.data = i_above;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r1_pos    <= i_pos;
            r1_sample <= i_sample;
        end
        if (advance && r1_pos.emit) begin
            r_out_edge <= strength > i_threshold;
            r_out_str  <= strength;
            r_out_col  <= r1_pos.col - t_coord'(1);
            r_out_row  <= r1_pos.row - t_coord'(1);
            r_out_last <= r1_pos.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_centre    <= '0;
            r_left      <= '0;
            r_up        <= '0;
            r_below     <= '0;
        end else begin
            if (i_accept) begin
                r1_valid <= 1'b1;
            end else if (advance) begin
                r1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r1_pos.emit;
                r_left      <= r_centre;
                r_centre    <= i_above;
                r_up        <= i_two_above;
                r_below     <= r1_sample;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_last  = r_out_last;
    assign o_m_data  = {5'b0, r_out_row, r_out_col, r_out_str, r_out_edge};

    `LZCE_ASSERT_NEXT(a_interior_reported, i_clk, i_rst_n, advance && r1_pos.emit,
        r_out_valid, "interior pixel left the window stage without a result")

endmodule

// ----- sv/laplacian_zero_crossing_edge.sv -----
// ---------------------------------------------------------------------------
// laplacian_zero_crossing_edge
// Streaming zero-crossing edge detector on signed Laplacian samples.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: sample_value[15:0]; tuser: frame_start
//  m_axis    out        tdata: edge_flag, crossing_strength, out_column,
//                       out_row; tlast: frame_done
//  cfg       in         write: frame_width, frame_height, edge_threshold
//
//  One sample per cycle while m_axis is not stalled; a result passes the line
//  store read, then the result register, after the sample completing its window.
//  Synchronous active-low reset; the row memories need no clearing pass,
//  a fill count masks entries not yet written.
//  A stall on m_axis holds the window stage and drops s_axis_tready.
// ---------------------------------------------------------------------------
module laplacian_zero_crossing_edge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // sample_value[15:0]
    input  logic                                s_axis_tuser,  // frame_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] edge_flag, [18:1] crossing_strength, [30:19] out_column,
    // [42:31] out_row, [47:43] zero
    output logic [lzce_pkg::OutDataBits-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,  // frame_done
    input  logic                                i_cfg_we,
    input  logic [lzce_pkg::CfgAddrBits-1:0]    i_cfg_addr,
    input  logic [lzce_pkg::ThrBits-1:0]        i_cfg_wdata
);
    import lzce_pkg::*;

    logic    accept;
    t_pos    pos;
    t_thresh threshold;
    t_sample above;
    t_sample two_above;
    t_wb     wb;

    assign accept = s_axis_tvalid && s_axis_tready;

    lzce_position u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (accept),
        .i_frame_start (s_axis_tuser),
        .o_pos         (pos),
        .o_threshold   (threshold)
    );

    lzce_line_store u_line_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_col    (pos.col),
        .i_sample    (t_sample'(s_axis_tdata)),
        .i_wb        (wb),
        .o_above     (above),
        .o_two_above (two_above)
    );

    lzce_crossing u_crossing (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_sample    (t_sample'(s_axis_tdata)),
        .i_pos       (pos),
        .i_above     (above),
        .i_two_above (two_above),
        .i_threshold (threshold),
        .i_m_tready  (m_axis_tready),
        .o_s_ready   (s_axis_tready),
        .o_wb        (wb),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata),
        .o_m_last    (m_axis_tlast)
    );

endmodule

// ----- bench/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the zero-crossing edge detector. Two hand-worked
// frames come first: sign extremes, zero centres with and without a stand-in,
// and a strength equal to the threshold. Random frames follow: clean, cut
// short, without a frame start, and noisy. Geometry and threshold change
// between them, the largest sizes among them. Every result is checked field
// by field against hand-worked values or a raster model kept in the bench.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzce_pkg::*;

    localparam int GapMax        = 18;
    localparam int DrainPad      = 8;
    localparam int TailCycles    = 16;
    localparam int StallCycles   = 200;
    localparam int WatchdogLimit = 2000;
    localparam int RandomItems   = 1100;
    localparam int ReportCap     = 40;
    localparam int StrengthCeil  = 262143;

    typedef struct packed {
        logic      edge_flag;
        t_strength strength;
        t_coord    col;
        t_coord    row;
        logic      done;
    } t_edge_pixel;

    typedef struct packed {
        t_sample     sample;
        logic        frame_start;
        logic [17:0] geom;
        logic        typed;
        t_edge_pixel want;
    } t_stim_row;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_NO_START,
        FRAME_CUT,
        FRAME_NOISE
    } t_frame_kind;

    localparam t_edge_pixel NoPixel = '0;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OutDataBits-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_we      = 1'b0;
    logic [CfgAddrBits-1:0] i_cfg_addr    = '0;
    logic [ThrBits-1:0]     i_cfg_wdata   = '0;

    // raster model state
    t_sample     line_above     [MaxWidth] = '{default: '0};
    t_sample     line_two_above [MaxWidth] = '{default: '0};
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    t_sample     win_centre = '0;
    t_sample     win_left   = '0;
    t_sample     win_up     = '0;
    t_sample     win_below  = '0;
    t_dim        geo_width  = WidthReset;
    t_dim        geo_height = HeightReset;
    t_thresh     edge_floor = ThrReset;

    t_edge_pixel pending_edges [$];
    int          mismatch_count = 0;
    int          stall_request  = 0;
    bit          src_steady     = 1'b0;
    bit          sink_steady    = 1'b0;

    // frame 1 is 5 wide, frame 2 is 4 wide; both 3 high (height word 2 clamps)
    t_stim_row directed_rows [27] = '{
        '{16'sd0,     1'b1, 18'h3E005, 1'b0, NoPixel},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{-16'sd1,    1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd1,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sh8000,  1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sh7FFF,  1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{-16'sd5,    1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sh7FFF,  1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sh8000,  1'b0, 18'd0,     1'b1, '{1'b1, 18'd131070, 12'd1, 12'd1, 1'b0}},
        '{16'sd9,     1'b0, 18'd0,     1'b1, '{1'b1, 18'd65535, 12'd2, 12'd1, 1'b0}},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd0,     1'b1, 18'd4,     1'b0, NoPixel},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd5,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{-16'sd7,    1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd3,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd0,     1'b0, 18'd0,     1'b0, NoPixel},
        '{16'sd4,     1'b0, 18'd0,     1'b0, NoPixel},
        '{-16'sd2,    1'b0, 18'd0,     1'b1, '{1'b1, 18'd12, 12'd1, 12'd1, 1'b0}},
        '{16'sd0,     1'b0, 18'd0,     1'b1, '{1'b0, 18'd10, 12'd2, 12'd1, 1'b1}}
    };

    laplacian_zero_crossing_edge i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned fit_dim(t_dim v);
        if (v < DimMin) begin
            return DimMin;
        end
        if (v > MaxWidth) begin
            return MaxWidth;
        end
        return v;
    endfunction

    function automatic int crossing_part(int a, int b, int stand_in);
        int lead;
        lead = (a == 0) ? stand_in : a;
        if ((lead < 0 && b > 0) || (lead > 0 && b < 0)) begin
            return (lead < 0 ? -lead : lead) + (b < 0 ? -b : b);
        end
        return 0;
    endfunction

    task automatic predict_crossing(input t_sample v, input logic fs,
                                    output bit hit, output t_edge_pixel px);
        int unsigned w, h, st;
        t_sample     above, two_above;
        w = fit_dim(geo_width);
        h = fit_dim(geo_height);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        above     = line_above[col_pos];
        two_above = line_two_above[col_pos];
        hit = row_pos >= 2 && row_pos < h && col_pos >= 2 && col_pos < w;
        px  = NoPixel;
        if (hit) begin
            st = crossing_part(win_centre, above, win_left)
               + crossing_part(win_centre, win_below, win_up);
            if (st > StrengthCeil) begin
                st = StrengthCeil;
            end
            px.edge_flag = st > edge_floor;
            px.strength  = t_strength'(st);
            px.col       = t_coord'(col_pos - 1);
            px.row       = t_coord'(row_pos - 1);
            px.done      = row_pos == h - 1 && col_pos == w - 1;
        end
        win_left   = win_centre;
        win_centre = above;
        win_up     = two_above;
        win_below  = v;
        line_two_above[col_pos] = above;
        line_above[col_pos]     = v;
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
        mismatch_count++;
        if (mismatch_count <= ReportCap) begin
            $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
        end
    endtask

    task automatic check_pixel(input logic [OutDataBits-1:0] data, input logic last);
        t_edge_pixel want;
        if (pending_edges.size() == 0) begin
            flag_mismatch("unexpected result", data, '0);
        end else begin
            want = pending_edges.pop_front();
            if (data[0] !== want.edge_flag) begin
                flag_mismatch("edge_flag", data[0], want.edge_flag);
            end
            if (data[18:1] !== want.strength) begin
                flag_mismatch("crossing_strength", data[18:1], want.strength);
            end
            if (data[30:19] !== want.col) begin
                flag_mismatch("out_column", data[30:19], want.col);
            end
            if (data[42:31] !== want.row) begin
                flag_mismatch("out_row", data[42:31], want.row);
            end
            if (data[47:43] !== '0) begin
                flag_mismatch("tdata padding", data[47:43], '0);
            end
            if (last !== want.done) begin
                flag_mismatch("frame_done", last, want.done);
            end
        end
    endtask

    task automatic offer_sample(input t_sample v, input logic fs, input logic typed,
                                input t_edge_pixel want);
        int          gap;
        bit          hit;
        t_edge_pixel px;
        gap = src_steady ? 0 : $urandom_range(0, GapMax);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= fs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_crossing(v, fs, hit, px);
        if (typed) begin
            pending_edges.push_back(want);
        end else if (hit) begin
            pending_edges.push_back(px);
        end
    endtask

    // wait out every expected result, then the pipeline
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (DrainPad) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [17:0] width_word, input logic [17:0] height_word,
                                input logic [17:0] thresh_word);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_FRAME_WIDTH;
        i_cfg_wdata <= width_word;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_FRAME_HEIGHT;
        i_cfg_wdata <= height_word;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_EDGE_THRESHOLD;
        i_cfg_wdata <= thresh_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        geo_width  = width_word[DimBits-1:0];
        geo_height = height_word[DimBits-1:0];
        edge_floor = thresh_word;
    endtask

    function automatic t_sample draw_sample();
        case ($urandom_range(0, 4))
            0: return t_sample'(int'($urandom_range(0, 8)) - 4);
            1: return '0;
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [17:0] dim_word(int unsigned typ_hi, int unsigned wide_hi);
        int unsigned v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 2);
            1: v = $urandom_range(typ_hi + 1, wide_hi);
            default: v = $urandom_range(3, typ_hi);
        endcase
        return {5'($urandom), 13'(v)};
    endfunction

    function automatic logic [17:0] thresh_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 18'd131072;
            2: return '1;
            3: return 18'($urandom_range(0, 40));
            default: return 18'($urandom_range(0, 70000));
        endcase
    endfunction

    initial begin : sink
        int hold;
        wait (i_rst_n);
        forever begin
            if (stall_request != 0) begin
                hold = stall_request;
                stall_request = 0;
            end else begin
                hold = sink_steady ? 0 : $urandom_range(0, GapMax);
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            check_pixel(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WatchdogLimit) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int          fed;
        int          frame_no;
        int unsigned n;
        bit          wide_frame;
        logic        fs;
        t_frame_kind kind;
        int          pick;
        fed      = 0;
        frame_no = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].geom != '0) begin
                program_regs(directed_rows[i].geom, 18'd2, 18'd10);
            end
            offer_sample(directed_rows[i].sample, directed_rows[i].frame_start,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        while (fed < RandomItems) begin
            frame_no++;
            wide_frame  = 1'b0;
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            kind = pick < 7 ? FRAME_CLEAN : pick == 7 ? FRAME_NO_START :
                   pick == 8 ? FRAME_CUT : FRAME_NOISE;
            if (frame_no == 4) begin
                // hold the result side off while samples keep coming
                program_regs(18'd24, 18'd12, thresh_word());
                kind          = FRAME_CLEAN;
                src_steady    = 1'b1;
                stall_request = StallCycles;
            end else if (frame_no == 8) begin
                program_regs({5'($urandom), 13'h1FFF}, 18'd3, thresh_word());
                kind       = FRAME_CLEAN;
                wide_frame = 1'b1;
                src_steady = 1'b1;
            end else if (frame_no == 14) begin
                program_regs(18'd3, {5'($urandom), 13'h1FFF}, thresh_word());
                kind       = FRAME_CLEAN;
                wide_frame = 1'b1;
                src_steady = 1'b1;
            end else if (frame_no == 1 || frame_no == 9 || frame_no == 15 ||
                         $urandom_range(0, 1) == 0) begin
                program_regs(dim_word(16, 40), dim_word(8, 14), thresh_word());
            end
            n = fit_dim(geo_width) * fit_dim(geo_height);
            case (kind)
                FRAME_CUT:   n = $urandom_range(1, n - 1);
                FRAME_NOISE: n = $urandom_range(1, 2 * n);
                default:     ;
            endcase
            if (wide_frame) begin
                n = $urandom_range(200, 360);
            end
            for (int k = 0; k < n; k++) begin
                case (kind)
                    FRAME_NO_START: fs = 1'b0;
                    FRAME_NOISE:    fs = ($urandom_range(0, 7) == 0);
                    default:        fs = (k == 0);
                endcase
                offer_sample(draw_sample(), fs, 1'b0, NoPixel);
            end
            fed += n;
        end

        settle();
        repeat (TailCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
